@@ rtl/stereo_cascaded_biquad_eq_macros.svh @@
`ifndef STEREO_CASCADED_BIQUAD_EQ_MACROS_SVH
`define STEREO_CASCADED_BIQUAD_EQ_MACROS_SVH

// Same-cycle implication check.
`define SCBEQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scbeq: same-cycle check failed");

// Next-cycle implication check.
`define SCBEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scbeq: next-cycle check failed");

`endif

@@ rtl/scbeq_pkg.sv @@
package scbeq_pkg;

   localparam int IO_WIDTH         = 24;
   localparam int COEF_WIDTH       = 28;
   localparam int SLOT_COUNT       = 5;
   localparam int BAND_FIELD_WIDTH = 3;
   localparam int SLOT_FIELD_WIDTH = 3;

   localparam logic OP_COEF_WRITE = 1'b0;
   localparam logic OP_SAMPLE     = 1'b1;

   localparam logic [SLOT_FIELD_WIDTH-1:0] SLOT_B0 = 3'd0;
   localparam logic [SLOT_FIELD_WIDTH-1:0] SLOT_B1 = 3'd1;
   localparam logic [SLOT_FIELD_WIDTH-1:0] SLOT_B2 = 3'd2;
   localparam logic [SLOT_FIELD_WIDTH-1:0] SLOT_A1 = 3'd3;
   localparam logic [SLOT_FIELD_WIDTH-1:0] SLOT_A2 = 3'd4;

   typedef struct packed {
      logic signed [COEF_WIDTH-1:0] b0;
      logic signed [COEF_WIDTH-1:0] b1;
      logic signed [COEF_WIDTH-1:0] b2;
      logic signed [COEF_WIDTH-1:0] a1;
      logic signed [COEF_WIDTH-1:0] a2;
   } coef_row_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic acc;
   } lane_ctrl_type;

endpackage

@@ rtl/scbeq_if.sv @@
interface scbeq_req_if;
   import scbeq_pkg::*;

   logic                               valid;
   logic                               ready;
   logic                               opcode;
   logic signed [IO_WIDTH-1:0]         left_sample;
   logic signed [IO_WIDTH-1:0]         right_sample;
   logic        [BAND_FIELD_WIDTH-1:0] coef_band;
   logic        [SLOT_FIELD_WIDTH-1:0] coef_slot;
   logic signed [COEF_WIDTH-1:0]       coef_value;

   modport source (
      output valid, opcode, left_sample, right_sample, coef_band, coef_slot, coef_value,
      input  ready
   );
   modport sink (
      input  valid, opcode, left_sample, right_sample, coef_band, coef_slot, coef_value,
      output ready
   );
endinterface

interface scbeq_rsp_if;
   import scbeq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [IO_WIDTH-1:0] left_out;
   logic signed [IO_WIDTH-1:0] right_out;

   modport source (output valid, left_out, right_out, input ready);
   modport sink (input valid, left_out, right_out, output ready);
endinterface

@@ rtl/scbeq_coef_bank.sv @@
module scbeq_coef_bank #(
   parameter int BAND_COUNT = 7,
   parameter int COEF_FRACTION_BITS = 24,
   localparam int BAND_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              wr_en,
   input  logic [scbeq_pkg::BAND_FIELD_WIDTH-1:0]            wr_band,
   input  logic [scbeq_pkg::SLOT_FIELD_WIDTH-1:0]            wr_slot,
   input  logic signed [scbeq_pkg::COEF_WIDTH-1:0]           wr_value,
   input  logic [BAND_W-1:0]                                 rd_band,
   output scbeq_pkg::coef_row_type                           rd_row
);
   import scbeq_pkg::*;

   // Unity gain saturates when the fraction leaves no room for the integer bit.
   localparam logic signed [COEF_WIDTH-1:0] UNITY =
      (COEF_FRACTION_BITS >= COEF_WIDTH - 1) ? {1'b0, {(COEF_WIDTH-1){1'b1}}}
                                            : COEF_WIDTH'(64'd1 << COEF_FRACTION_BITS);

   coef_row_type             row_ff [BAND_COUNT];
   logic                     wr_hit;
   logic [BAND_W-1:0]        wr_idx;

   assign wr_hit = wr_en && (int'(wr_band) < BAND_COUNT);
   assign wr_idx = BAND_W'(wr_band);
   assign rd_row = row_ff[rd_band];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < BAND_COUNT; b++) begin
            row_ff[b] <= '{b0: UNITY, default: '0};
         end
      end else if (wr_hit) begin
         unique case (wr_slot)
            SLOT_B0: row_ff[wr_idx].b0 <= wr_value;
            SLOT_B1: row_ff[wr_idx].b1 <= wr_value;
            SLOT_B2: row_ff[wr_idx].b2 <= wr_value;
            SLOT_A1: row_ff[wr_idx].a1 <= wr_value;
            SLOT_A2: row_ff[wr_idx].a2 <= wr_value;
            default: ;
         endcase
      end
   end

endmodule

@@ rtl/scbeq_lane.sv @@
module scbeq_lane #(
   parameter int BAND_COUNT = 7,
   parameter int SAMPLE_WIDTH = 24,
   parameter int COEF_FRACTION_BITS = 24,
   localparam int BAND_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  scbeq_pkg::lane_ctrl_type                ctrl,
   input  logic [BAND_W-1:0]                       band,
   input  scbeq_pkg::coef_row_type                 coef,
   input  logic signed [scbeq_pkg::IO_WIDTH-1:0]   sample_in,
   output logic signed [scbeq_pkg::IO_WIDTH-1:0]   sample_out
);
   import scbeq_pkg::*;

   localparam int SW     = SAMPLE_WIDTH;
   localparam int EXT_W  = (SW > IO_WIDTH) ? SW : IO_WIDTH;
   localparam int PROD_W = COEF_WIDTH + SW;
   localparam int ACC_W  = PROD_W + 3;

   localparam logic signed [EXT_W-1:0] IN_MAX = {{(EXT_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [EXT_W-1:0] IN_MIN = ~IN_MAX;
   localparam logic signed [ACC_W-1:0] ACC_MAX = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = ~ACC_MAX;
   localparam logic signed [ACC_W-1:0] HALF =
      {{(ACC_W-COEF_FRACTION_BITS){1'b0}}, 1'b1, {(COEF_FRACTION_BITS-1){1'b0}}};

   typedef struct packed {
      logic signed [SW-1:0] x1;
      logic signed [SW-1:0] x2;
      logic signed [SW-1:0] y1;
      logic signed [SW-1:0] y2;
   } hist_row_type;

   hist_row_type              hist_ff [BAND_COUNT];
   hist_row_type              row;
   logic signed [SW-1:0]      x_ff, x_in;
   logic signed [PROD_W-1:0]  p_b0_ff, p_b1_ff, p_b2_ff, p_a1_ff, p_a2_ff;
   logic signed [PROD_W-1:0]  p_b0_in, p_b1_in, p_b2_in, p_a1_in, p_a2_in;
   logic signed [EXT_W-1:0]   in_ext;
   logic signed [SW-1:0]      in_sat;
   logic signed [ACC_W-1:0]   sum, shifted;
   logic signed [SW-1:0]      y;

   always_comb begin
      row = hist_ff[band];

      in_ext = EXT_W'(sample_in);
      if (in_ext > IN_MAX) begin
         in_sat = IN_MAX[SW-1:0];
      end else if (in_ext < IN_MIN) begin
         in_sat = IN_MIN[SW-1:0];
      end else begin
         in_sat = in_ext[SW-1:0];
      end

      p_b0_in = PROD_W'($signed(coef.b0)) * PROD_W'(x_ff);
      p_b1_in = PROD_W'($signed(coef.b1)) * PROD_W'(row.x1);
      p_b2_in = PROD_W'($signed(coef.b2)) * PROD_W'(row.x2);
      p_a1_in = PROD_W'($signed(coef.a1)) * PROD_W'(row.y1);
      p_a2_in = PROD_W'($signed(coef.a2)) * PROD_W'(row.y2);

      // Round half up, then an arithmetic shift gives the floor.
      sum = ACC_W'(p_b0_ff) + ACC_W'(p_b1_ff) + ACC_W'(p_b2_ff)
          - ACC_W'(p_a1_ff) - ACC_W'(p_a2_ff) + HALF;
      shifted = sum >>> COEF_FRACTION_BITS;
      if (shifted > ACC_MAX) begin
         y = ACC_MAX[SW-1:0];
      end else if (shifted < ACC_MIN) begin
         y = ACC_MIN[SW-1:0];
      end else begin
         y = shifted[SW-1:0];
      end

      x_in = x_ff;
      if (ctrl.load) begin
         x_in = in_sat;
      end else if (ctrl.acc) begin
         x_in = y;
      end
   end

   assign sample_out = IO_WIDTH'(x_ff);

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      if (ctrl.mul) begin
         p_b0_ff <= p_b0_in;
         p_b1_ff <= p_b1_in;
         p_b2_ff <= p_b2_in;
         p_a1_ff <= p_a1_in;
         p_a2_ff <= p_a2_in;
      end
      if (reset) begin
         for (int b = 0; b < BAND_COUNT; b++) begin
            hist_ff[b] <= '0;
         end
      end else if (ctrl.acc) begin
         hist_ff[band] <= '{x1: x_ff, x2: row.x1, y1: y, y2: row.y1};
      end
   end

endmodule

@@ rtl/stereo_cascaded_biquad_eq.sv @@
// Stereo graphic equalizer built from BAND_COUNT direct-form-I biquad sections per channel.
// A sample beat runs the left and right channels side by side in two lanes that share one
// coefficient table; each band takes a multiply state (five products in parallel, registered)
// and then an accumulate state (the sum with rounding and saturation). After the last band
// the pair moves to the output register. A coefficient write beat is accepted from idle and
// produces no result. The result sits in an output register, so the next beat is accepted
// while an earlier result waits to be taken; a finished pair only stalls when that register
// is still full.
`include "stereo_cascaded_biquad_eq_macros.svh"

module stereo_cascaded_biquad_eq #(
   parameter int BAND_COUNT = 7,
   parameter int SAMPLE_WIDTH = 24,
   parameter int COEF_FRACTION_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   scbeq_req_if.sink   req_bus,
   scbeq_rsp_if.source rsp_bus
);
   import scbeq_pkg::*;

   localparam int BAND_W = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
   localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(BAND_COUNT - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_OUT
   } state_type;

   state_type                  state_ff;
   logic [BAND_W-1:0]          band_ff;
   logic                       rsp_valid_ff;
   logic signed [IO_WIDTH-1:0] left_out_ff, right_out_ff;
   logic                       accept;
   logic                       rsp_free;
   lane_ctrl_type              ctrl;
   coef_row_type               coef_row;
   logic signed [IO_WIDTH-1:0] left_result, right_result;

   assign req_bus.ready   = (state_ff == ST_IDLE);
   assign accept          = req_bus.valid && req_bus.ready;
   assign rsp_free        = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.left_out  = left_out_ff;
   assign rsp_bus.right_out = right_out_ff;

   always_comb begin
      ctrl.load = accept && (req_bus.opcode == OP_SAMPLE);
      ctrl.mul  = (state_ff == ST_MUL);
      ctrl.acc  = (state_ff == ST_ACC);
   end

   scbeq_coef_bank #(
      .BAND_COUNT         (BAND_COUNT),
      .COEF_FRACTION_BITS (COEF_FRACTION_BITS)
   ) u_coef_bank (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept && (req_bus.opcode == OP_COEF_WRITE)),
      .wr_band  (req_bus.coef_band),
      .wr_slot  (req_bus.coef_slot),
      .wr_value (req_bus.coef_value),
      .rd_band  (band_ff),
      .rd_row   (coef_row)
   );

   scbeq_lane #(
      .BAND_COUNT         (BAND_COUNT),
      .SAMPLE_WIDTH       (SAMPLE_WIDTH),
      .COEF_FRACTION_BITS (COEF_FRACTION_BITS)
   ) u_lane_left (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .band       (band_ff),
      .coef       (coef_row),
      .sample_in  (req_bus.left_sample),
      .sample_out (left_result)
   );

   scbeq_lane #(
      .BAND_COUNT         (BAND_COUNT),
      .SAMPLE_WIDTH       (SAMPLE_WIDTH),
      .COEF_FRACTION_BITS (COEF_FRACTION_BITS)
   ) u_lane_right (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .band       (band_ff),
      .coef       (coef_row),
      .sample_in  (req_bus.right_sample),
      .sample_out (right_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         band_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In the output state the valid flag is handled by the state itself.
         if (rsp_valid_ff && rsp_bus.ready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (ctrl.load) begin
                  band_ff  <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (band_ff == LAST_BAND) begin
                  state_ff <= ST_OUT;
               end else begin
                  band_ff  <= band_ff + 1'b1;
                  state_ff <= ST_MUL;
               end
            end
            ST_OUT: begin
               // Both lanes finish together; their results merge into one beat.
               if (rsp_free) begin
                  left_out_ff  <= left_result;
                  right_out_ff <= right_result;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `SCBEQ_ASSERT_NOW(a_rsp_rises_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_OUT)
   `SCBEQ_ASSERT_NEXT(a_sample_starts_band0, clock, reset, ctrl.load, (state_ff == ST_MUL) && (band_ff == '0))
   `SCBEQ_ASSERT_NEXT(a_last_band_finishes, clock, reset, (state_ff == ST_ACC) && (band_ff == LAST_BAND), state_ff == ST_OUT)
   `SCBEQ_ASSERT_NOW(a_band_in_range, clock, reset, state_ff != ST_IDLE, band_ff <= LAST_BAND)
   `SCBEQ_ASSERT_NEXT(a_out_blocked_holds, clock, reset, (state_ff == ST_OUT) && !rsp_free, (state_ff == ST_OUT) && rsp_valid_ff)

endmodule
